/* src/abip_pkg.sv */
// ----------------------------------------------------------------------------
// abip_pkg: shared types and constants of the auto-base integer parser
// Character codes, the token passed from classifier to parser, parse modes,
// number bases and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abip_pkg;

  // Default signed width of the parsed value and depth of the token queue
  localparam int ValueBitsDefault  = 32;
  localparam int QueueDepthDefault = 2;

  localparam int CharBits  = 8;
  localparam int ValueOutW = 32;

  localparam logic [CharBits-1:0] CharNul   = 8'h00;
  localparam logic [CharBits-1:0] CharPlus  = 8'h2B;
  localparam logic [CharBits-1:0] CharMinus = 8'h2D;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharOne   = 8'h31;
  localparam logic [CharBits-1:0] CharSeven = 8'h37;
  localparam logic [CharBits-1:0] CharNine  = 8'h39;
  localparam logic [CharBits-1:0] CharUpA   = 8'h41;
  localparam logic [CharBits-1:0] CharUpF   = 8'h46;
  localparam logic [CharBits-1:0] CharLowA  = 8'h61;
  localparam logic [CharBits-1:0] CharLowB  = 8'h62;
  localparam logic [CharBits-1:0] CharLowF  = 8'h66;
  localparam logic [CharBits-1:0] CharLowX  = 8'h78;

  // Classified character, one per queue entry
  typedef struct packed {
    logic       is_nul;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       is_dec;
    logic       is_oct;
    logic       is_bin;
    logic       is_hex;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [3:0] {
    MODE_START      = 4'd0,
    MODE_SIGNED     = 4'd1,
    MODE_ZERO       = 4'd2,
    MODE_HEX_FIRST  = 4'd3,
    MODE_HEX        = 4'd4,
    MODE_BIN_FIRST  = 4'd5,
    MODE_BIN        = 4'd6,
    MODE_OCT        = 4'd7,
    MODE_DEC        = 4'd8,
    MODE_STOP_OK    = 4'd9,
    MODE_STOP_EMPTY = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2,
    BASE_16 = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* src/abip_front.sv */
// ----------------------------------------------------------------------------
// abip_front: character classifier
// Accepts characters while the queue has room and turns each into a token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abip_front (
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [abip_pkg::CharBits-1:0] char_i,
  input  wire logic                          queue_full_i,
  output logic                               push_o,
  output abip_pkg::token_t                   token_o
);

  logic is_dec;
  logic is_upper_hex;
  logic is_lower_hex;

  assign ready_o = !queue_full_i;
  assign push_o  = valid_i && !queue_full_i;

  assign is_dec       = (char_i >= abip_pkg::CharZero) && (char_i <= abip_pkg::CharNine);
  assign is_upper_hex = (char_i >= abip_pkg::CharUpA) && (char_i <= abip_pkg::CharUpF);
  assign is_lower_hex = (char_i >= abip_pkg::CharLowA) && (char_i <= abip_pkg::CharLowF);

  always_comb begin
    token_o.is_nul   = (char_i == abip_pkg::CharNul);
    token_o.is_plus  = (char_i == abip_pkg::CharPlus);
    token_o.is_minus = (char_i == abip_pkg::CharMinus);
    token_o.is_zero  = (char_i == abip_pkg::CharZero);
    token_o.is_x     = (char_i == abip_pkg::CharLowX);
    token_o.is_b     = (char_i == abip_pkg::CharLowB);
    token_o.is_dec   = is_dec;
    token_o.is_oct   = (char_i >= abip_pkg::CharZero) && (char_i <= abip_pkg::CharSeven);
    token_o.is_bin   = (char_i == abip_pkg::CharZero) || (char_i == abip_pkg::CharOne);
    token_o.is_hex   = is_dec || is_upper_hex || is_lower_hex;
    // letters A-F and a-f carry 1..6 in their low nibble
    token_o.digit    = is_dec ? char_i[3:0] : (char_i[3:0] + 4'd9);
  end

endmodule

`default_nettype wire

/* src/abip_fifo.sv */
// ----------------------------------------------------------------------------
// abip_fifo: token queue
// Short register queue between classifier and parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abip_fifo #(
  parameter int Depth = abip_pkg::QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire abip_pkg::token_t token_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output abip_pkg::token_t      token_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  abip_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

`default_nettype wire

/* src/abip_back.sv */
// ----------------------------------------------------------------------------
// abip_back: parser and result register
// Runs the base-selection state machine over queued tokens, accumulates
// digits with a range check, and holds each result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abip_back #(
  parameter int ValueBits = abip_pkg::ValueBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           tok_valid_i,
  input  wire abip_pkg::token_t               tok_i,
  output logic                                pop_o,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output logic [abip_pkg::ValueOutW-1:0]      res_value_o,
  output abip_pkg::status_e                   res_status_o
);

  localparam int SumW = ValueBits + 5;
  localparam logic [ValueBits-1:0] NegMag = {1'b1, {(ValueBits-1){1'b0}}};
  localparam logic [ValueBits-1:0] PosMag = {1'b0, {(ValueBits-1){1'b1}}};

  abip_pkg::mode_e   mode_q, mode_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic [ValueBits-1:0] acc_q, acc_d;

  logic              out_valid_q;
  logic [abip_pkg::ValueOutW-1:0] out_value_q;
  abip_pkg::status_e out_status_q;

  logic              do_acc;
  abip_pkg::base_e   base;
  abip_pkg::mode_e   acc_next;
  logic [SumW-1:0]   acc_ext, scaled, sum, lim;

  abip_pkg::status_e    res_status;
  logic [ValueBits-1:0] res_value;
  logic [abip_pkg::ValueOutW-1:0] res_value_ext;

  // Hold a NUL token back while the result register is occupied and not being taken
  assign pop_o = tok_valid_i && (!tok_i.is_nul || !out_valid_q || res_ready_i);

  // Select base, digit action and mode successor
  always_comb begin
    do_acc   = 1'b0;
    base     = abip_pkg::BASE_10;
    acc_next = abip_pkg::MODE_DEC;
    mode_d   = mode_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    acc_d    = acc_q;
    unique case (mode_q)
      abip_pkg::MODE_START, abip_pkg::MODE_SIGNED: begin
        if (mode_q == abip_pkg::MODE_START && tok_i.is_plus) begin
          mode_d = abip_pkg::MODE_SIGNED;
        end else if (mode_q == abip_pkg::MODE_START && tok_i.is_minus) begin
          neg_d  = 1'b1;
          mode_d = abip_pkg::MODE_SIGNED;
        end else if (tok_i.is_zero) begin
          mode_d = abip_pkg::MODE_ZERO;
        end else if (tok_i.is_dec) begin
          do_acc = 1'b1;
        end else begin
          mode_d = abip_pkg::MODE_STOP_EMPTY;
        end
      end
      abip_pkg::MODE_ZERO: begin
        if (tok_i.is_x) begin
          mode_d = abip_pkg::MODE_HEX_FIRST;
        end else if (tok_i.is_b) begin
          mode_d = abip_pkg::MODE_BIN_FIRST;
        end else if (tok_i.is_oct) begin
          do_acc   = 1'b1;
          base     = abip_pkg::BASE_8;
          acc_next = abip_pkg::MODE_OCT;
        end else begin
          mode_d = abip_pkg::MODE_STOP_OK;
        end
      end
      abip_pkg::MODE_HEX_FIRST, abip_pkg::MODE_HEX: begin
        base     = abip_pkg::BASE_16;
        acc_next = abip_pkg::MODE_HEX;
        if (tok_i.is_hex) begin
          do_acc = 1'b1;
        end else if (mode_q == abip_pkg::MODE_HEX_FIRST) begin
          mode_d = abip_pkg::MODE_STOP_EMPTY;
        end
      end
      abip_pkg::MODE_BIN_FIRST, abip_pkg::MODE_BIN: begin
        base     = abip_pkg::BASE_2;
        acc_next = abip_pkg::MODE_BIN;
        if (tok_i.is_bin) begin
          do_acc = 1'b1;
        end else if (mode_q == abip_pkg::MODE_BIN_FIRST) begin
          mode_d = abip_pkg::MODE_STOP_EMPTY;
        end else begin
          mode_d = abip_pkg::MODE_STOP_OK;
        end
      end
      abip_pkg::MODE_OCT: begin
        base     = abip_pkg::BASE_8;
        acc_next = abip_pkg::MODE_OCT;
        if (tok_i.is_oct) begin
          do_acc = 1'b1;
        end else begin
          mode_d = abip_pkg::MODE_STOP_OK;
        end
      end
      abip_pkg::MODE_DEC: begin
        if (tok_i.is_dec) begin
          do_acc = 1'b1;
        end else begin
          mode_d = abip_pkg::MODE_STOP_OK;
        end
      end
      abip_pkg::MODE_STOP_OK: begin
        mode_d = mode_q;
      end
      default: begin
        mode_d = abip_pkg::MODE_STOP_EMPTY;
      end
    endcase

    // Scale by the base with shifts, add the digit, compare against the limit
    acc_ext = SumW'(acc_q);
    unique case (base)
      abip_pkg::BASE_2:  scaled = acc_ext << 1;
      abip_pkg::BASE_8:  scaled = acc_ext << 3;
      abip_pkg::BASE_10: scaled = (acc_ext << 3) + (acc_ext << 1);
      default:           scaled = acc_ext << 4;
    endcase
    sum = scaled + SumW'(tok_i.digit);
    lim = neg_q ? SumW'(NegMag) : SumW'(PosMag);
    if (do_acc) begin
      if (sum > lim) begin
        ovf_d  = 1'b1;
        mode_d = abip_pkg::MODE_STOP_OK;
      end else begin
        acc_d  = sum[ValueBits-1:0];
        mode_d = acc_next;
      end
    end

    // End of string: drop all parse state
    if (tok_i.is_nul) begin
      mode_d = abip_pkg::MODE_START;
      neg_d  = 1'b0;
      ovf_d  = 1'b0;
      acc_d  = '0;
    end
  end

  // Result for a NUL arriving in the current mode
  always_comb begin
    res_status = abip_pkg::STATUS_EMPTY;
    res_value  = '0;
    unique case (mode_q)
      abip_pkg::MODE_ZERO: begin
        res_status = abip_pkg::STATUS_OK;
      end
      abip_pkg::MODE_HEX, abip_pkg::MODE_BIN, abip_pkg::MODE_OCT,
      abip_pkg::MODE_DEC, abip_pkg::MODE_STOP_OK: begin
        if (ovf_q) begin
          res_status = abip_pkg::STATUS_RANGE;
          res_value  = neg_q ? NegMag : PosMag;
        end else begin
          res_status = abip_pkg::STATUS_OK;
          res_value  = neg_q ? (~acc_q + 1'b1) : acc_q;
        end
      end
      default: begin
        res_status = abip_pkg::STATUS_EMPTY;
      end
    endcase
  end

  if (ValueBits >= abip_pkg::ValueOutW) begin : g_trunc
    assign res_value_ext = res_value[abip_pkg::ValueOutW-1:0];
  end else begin : g_sext
    assign res_value_ext = {{(abip_pkg::ValueOutW-ValueBits){res_value[ValueBits-1]}},
                            res_value};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= abip_pkg::MODE_START;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q <= mode_d;
        neg_q  <= neg_d;
        ovf_q  <= ovf_d;
        acc_q  <= acc_d;
      end
      if (pop_o && tok_i.is_nul) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && tok_i.is_nul) begin
      out_value_q  <= res_value_ext;
      out_status_q <= res_status;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = out_status_q;

  a_reset_after_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && tok_i.is_nul |=> mode_q == abip_pkg::MODE_START && !neg_q && !ovf_q
                              && acc_q == '0)
    else $error("parse state not cleared after end of string");

  a_acc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= NegMag)
    else $error("accumulator beyond signed range");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == abip_pkg::STATUS_EMPTY |-> out_value_q == '0)
    else $error("empty result with nonzero value");

  a_nul_held_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i && tok_valid_i && tok_i.is_nul |-> !pop_o)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

/* src/auto_base_integer_parser_core.sv */
// ----------------------------------------------------------------------------
// auto_base_integer_parser_core: streaming string-to-integer parser
// Result: registered at the edge that accepts its NUL character, when the
//   result register is free.
// Throughput: one character per cycle while results are taken, set by the single
//   parser step (one scale-add-compare per cycle on the accumulator register).
// A result that is not taken holds back the next NUL; characters ahead of it
//   keep flowing, and input stalls once the token queue fills behind it.
// Reset (rst_ni low, asynchronous): queue empty, parser at string start,
//   no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module auto_base_integer_parser_core #(
  parameter int ValueBits  = abip_pkg::ValueBitsDefault,   // 8 to 64
  parameter int QueueDepth = abip_pkg::QueueDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Character stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [abip_pkg::CharBits-1:0]  s_axis_tdata,  // [7:0] char_code
  // Result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [abip_pkg::ValueOutW-1:0]      m_axis_tdata,  // [31:0] parsed_value
  output logic [1:0]                          m_axis_tuser   // [1:0] status
);

  // Token path between the classifier and the parser
  logic             push;
  logic             queue_full;
  abip_pkg::token_t push_token;
  logic             pop;
  logic             tok_valid;
  abip_pkg::token_t tok;

  abip_pkg::status_e res_status;

  // Front: classify each accepted character; stall only on a full queue
  abip_front u_front (
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .char_i       (s_axis_tdata),
    .queue_full_i (queue_full),
    .push_o       (push),
    .token_o      (push_token)
  );

  // Queue: decouple character intake from the result handshake
  abip_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_token),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (tok_valid),
    .token_o (tok)
  );

  // Back: advance the parse one token per cycle unless a NUL is held back, and register each result
  abip_back #(
    .ValueBits (ValueBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (tok_valid),
    .tok_i        (tok),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_value_o  (m_axis_tdata),
    .res_status_o (res_status)
  );

  assign m_axis_tuser = res_status;

endmodule

`default_nettype wire
